### hdl/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOBHF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SOBHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sobhf_pkg.sv
// ----------------------------------------------------------------------------
// sobhf_pkg
// Shared types, widths and helpers of the horizontal Sobel edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sobhf_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Default frame limits and register reset value
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned CFG_RESET      = 1024;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [CFG_W-1:0] cfg_t;

  // One pixel request as it enters the read stage
  typedef struct packed {
    pix_t pixel;
    row_t row;
    col_t col;
    logic first_row;   // row 0: line store data not used
    logic top_ok;      // row >= 2: older line is valid
    logic second_col;  // column 1: left neighbor replicated
    logic has_result;  // row >= 1 and column >= 1
    logic flush_col;   // last column of the row
    logic last_row;    // last row of the frame
  } item_t;

  // Line store write-back from the read stage
  typedef struct packed {
    logic we_new;
    logic we_old;
    pix_t d_new;
    pix_t d_old;
  } lwr_t;

  // Up to four results caused by one pixel, in output order
  typedef struct packed {
    logic [3:0][PIX_W-1:0] mag;
    row_t row;
    col_t col;
    logic flush_col;
    logic last_row;
  } bundle_t;

  // Last valid index of a frame dimension, register clamped to [2, maxv]
  function automatic int unsigned clamp_last(input cfg_t v, input int unsigned maxv);
    int unsigned val;
    val = int'(v);
    if (val < 2) begin
      return 1;
    end else if (val > maxv) begin
      return maxv - 1;
    end
    return val - 1;
  endfunction

endpackage

`default_nettype wire

### hdl/sobel_horizontal_edge_filter_top.sv
// ----------------------------------------------------------------------------
// sobel_horizontal_edge_filter_top
// Streaming 3x3 horizontal Sobel gradient with two line-store RAMs.
// ----------------------------------------------------------------------------
// Takes one 8-bit grey pixel per cycle when ready in raster order and returns
// |right column - left column| (weights 1,2,1) saturated to 255, with the
// row and column of the filtered pixel; edge neighbors are replicated. A
// result for (r,c) leaves when pixel (r+1,c+1) is taken, so the first row
// and first column give nothing; a row-end pixel gives two results, a
// last-row pixel two, and the bottom-right pixel four. Results leave one per
// cycle through the output register while the output is ready, so input runs
// at one pixel per cycle wherever a pixel causes at most one result and is
// held back while each extra result leaves. The two line stores are
// single-port-write RAMs read at the pixel's column on acceptance and
// written back when the pixel leaves the read stage, which a stalled output
// side can delay; no clearing pass is needed.
// Writing either size register restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_horizontal_edge_filter_top #(
  parameter int unsigned MAX_WIDTH  = sobhf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobhf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [sobhf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  sobhf_pkg::cfg_t                cfg_wdata_i,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sobhf_pkg::pix_t                pixel_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sobhf_pkg::row_t                out_row_o,
  output sobhf_pkg::col_t                out_col_o,
  output sobhf_pkg::pix_t                magnitude_o,
  output logic                           last_of_run_o,
  output logic                           end_of_frame_o
);

  import sobhf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  logic [AW-1:0] wlast_q, wlast_d;
  logic [RW-1:0] hlast_q, hlast_d;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          accept;
  item_t         item;
  lwr_t          wr;
  logic [AW-1:0] waddr;
  pix_t          rd_new, rd_old;
  logic          bnd_valid, bnd_ready;
  bundle_t       bnd;

  assign accept = in_valid_i && in_ready_o;

  // size registers, stored as clamped last index; counters in raster order
  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH:  wlast_d = AW'(clamp_last(cfg_wdata_i, MAX_WIDTH));
        CFG_IDX_HEIGHT: hlast_d = RW'(clamp_last(cfg_wdata_i, MAX_HEIGHT));
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= AW'(clamp_last(CFG_W'(CFG_RESET), MAX_WIDTH));
      hlast_q <= RW'(clamp_last(CFG_W'(CFG_RESET), MAX_HEIGHT));
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // request descriptor for the read stage
  always_comb begin
    item.pixel      = pixel_i;
    item.row        = ROW_W'(row_q);
    item.col        = COL_W'(col_q);
    item.first_row  = (row_q == '0);
    item.top_ok     = (row_q > RW'(1));
    item.second_col = (col_q == AW'(1));
    item.has_result = (row_q != '0) && (col_q != '0);
    item.flush_col  = (col_q == wlast_q);
    item.last_row   = (row_q == hlast_q);
  end

  // line stores: newer holds row r-1, older row r-2
  sobhf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_new (
    .clk_i   (clk_i),
    .we_i    (wr.we_new),
    .waddr_i (waddr),
    .wdata_i (wr.d_new),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_new)
  );

  sobhf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_old (
    .clk_i   (clk_i),
    .we_i    (wr.we_old),
    .waddr_i (waddr),
    .wdata_i (wr.d_old),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_old)
  );

  sobhf_window #(
    .AW (AW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept),
    .item_i      (item),
    .addr_i      (col_q),
    .ready_o     (in_ready_o),
    .rd_new_i    (rd_new),
    .rd_old_i    (rd_old),
    .wr_o        (wr),
    .waddr_o     (waddr),
    .bnd_valid_o (bnd_valid),
    .bnd_o       (bnd),
    .bnd_ready_i (bnd_ready)
  );

  sobhf_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bnd_valid_i    (bnd_valid),
    .bnd_i          (bnd),
    .bnd_ready_o    (bnd_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .magnitude_o    (magnitude_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

`default_nettype wire

### hdl/sobhf_ram.sv
// ----------------------------------------------------------------------------
// sobhf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sobhf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/sobhf_window.sv
// ----------------------------------------------------------------------------
// sobhf_window
// Line store read stage: builds the 3x3 window, writes the line stores back
// and computes the gradient magnitudes of every result one pixel causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sobhf_window #(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel request from the front end
  input  logic               take_i,
  input  sobhf_pkg::item_t   item_i,
  input  logic [AW-1:0]      addr_i,
  output logic               ready_o,
  // line store data, read at take time
  input  sobhf_pkg::pix_t    rd_new_i,
  input  sobhf_pkg::pix_t    rd_old_i,
  // line store write-back
  output sobhf_pkg::lwr_t    wr_o,
  output logic [AW-1:0]      waddr_o,
  // result bundle
  output logic               bnd_valid_o,
  output sobhf_pkg::bundle_t bnd_o,
  input  logic               bnd_ready_i
);

  import sobhf_pkg::*;

  typedef struct packed {
    pix_t t;
    pix_t m;
    pix_t b;
  } wcol_t;

  logic          s1_valid_q, s1_valid_d;
  item_t         s1_item_q;
  logic [AW-1:0] s1_addr_q;
  wcol_t         col0_q, col1_q;   // two older window columns
  wcol_t         col_new;
  logic          adv;
  logic [9:0]    sn0, sn1, sn2, sl0, sl1, sl2;
  pix_t          mag_a, mag_b, mag_c, mag_d;

  // t + 2m + b
  function automatic logic [9:0] sum_norm(input wcol_t w);
    return {2'b00, w.t} + {1'b0, w.m, 1'b0} + {2'b00, w.b};
  endfunction

  // bottom row replicated: m + 3b
  function automatic logic [9:0] sum_low(input wcol_t w);
    return {2'b00, w.m} + {1'b0, w.b, 1'b0} + {2'b00, w.b};
  endfunction

  // |a - b| saturated to the pixel range
  function automatic pix_t abs_sat(input logic [9:0] a, input logic [9:0] b);
    logic [9:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return (diff > 10'(PIX_W'('1))) ? '1 : diff[PIX_W-1:0];
  endfunction

  // stage advances unless its results cannot be handed on
  assign adv         = s1_valid_q && (!s1_item_q.has_result || bnd_ready_i);
  assign ready_o     = !s1_valid_q || adv;
  assign bnd_valid_o = s1_valid_q && s1_item_q.has_result;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_i) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // new window column from the line stores and the current pixel
  always_comb begin
    col_new.b = s1_item_q.pixel;
    if (s1_item_q.first_row) begin
      col_new.m = s1_item_q.pixel;
      col_new.t = s1_item_q.pixel;
    end else begin
      col_new.m = rd_new_i;
      col_new.t = s1_item_q.top_ok ? rd_old_i : rd_new_i;
    end
  end

  // line store write-back; next access to this address is at least a row later
  always_comb begin
    wr_o.we_new = adv;
    wr_o.we_old = adv && !s1_item_q.first_row;
    wr_o.d_new  = s1_item_q.pixel;
    wr_o.d_old  = col_new.m;
  end
  assign waddr_o = s1_addr_q;

  // column sums of the shifted window
  assign sn0 = sum_norm(col0_q);
  assign sn1 = sum_norm(col1_q);
  assign sn2 = sum_norm(col_new);
  assign sl0 = sum_low(col0_q);
  assign sl1 = sum_low(col1_q);
  assign sl2 = sum_low(col_new);

  // left column replicated at column 1, right column replicated at row end
  assign mag_a = abs_sat(sn2, s1_item_q.second_col ? sn1 : sn0);
  assign mag_b = abs_sat(sn2, sn1);
  assign mag_c = abs_sat(sl2, s1_item_q.second_col ? sl1 : sl0);
  assign mag_d = abs_sat(sl2, sl1);

  // pack results in output order
  always_comb begin
    bnd_o.mag[0]    = mag_a;
    bnd_o.mag[1]    = s1_item_q.flush_col ? mag_b : mag_c;
    bnd_o.mag[2]    = mag_c;
    bnd_o.mag[3]    = mag_d;
    bnd_o.row       = s1_item_q.row;
    bnd_o.col       = s1_item_q.col;
    bnd_o.flush_col = s1_item_q.flush_col;
    bnd_o.last_row  = s1_item_q.last_row;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col0_q     <= '0;
      col1_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (adv) begin
        col0_q <= col1_q;
        col1_q <= col_new;
      end
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_item_q <= item_i;
      s1_addr_q <= addr_i;
    end
  end

endmodule

`default_nettype wire

### hdl/sobhf_emit.sv
// ----------------------------------------------------------------------------
// sobhf_emit
// Output register: holds one result bundle and sends its results one per
// handshake, tagging row, column, run end and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module sobhf_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bnd_valid_i,
  input  sobhf_pkg::bundle_t bnd_i,
  output logic               bnd_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sobhf_pkg::row_t    out_row_o,
  output sobhf_pkg::col_t    out_col_o,
  output sobhf_pkg::pix_t    magnitude_o,
  output logic               last_of_run_o,
  output logic               end_of_frame_o
);

  import sobhf_pkg::*;

  typedef enum logic [1:0] {
    SLOT_PREV_ROW = 2'd0,  // result above-left of the pixel
    SLOT_SECOND   = 2'd1,  // row-end flush or last-row result
    SLOT_LAST_ROW = 2'd2,  // last-row result when both flushes apply
    SLOT_CORNER   = 2'd3   // bottom-right pixel of the frame
  } slot_e;

  logic    valid_q, valid_d;
  bundle_t bnd_q;
  slot_e   idx_q, idx_d, idx_last;
  logic    at_last;
  row_t    row_m1;
  col_t    col_m1;

  // slot of the last result in the held bundle
  always_comb begin
    if (bnd_q.flush_col && bnd_q.last_row) begin
      idx_last = SLOT_CORNER;
    end else if (bnd_q.flush_col || bnd_q.last_row) begin
      idx_last = SLOT_SECOND;
    end else begin
      idx_last = SLOT_PREV_ROW;
    end
  end

  assign at_last     = (idx_q == idx_last);
  assign bnd_ready_o = !valid_q || (out_ready_i && at_last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (bnd_ready_o) begin
      valid_d = bnd_valid_i;
      idx_d   = SLOT_PREV_ROW;
    end else if (out_ready_i) begin
      idx_d = slot_e'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= SLOT_PREV_ROW;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_ready_o && bnd_valid_i) begin
      bnd_q <= bnd_i;
    end
  end

  // coordinates of the current slot
  assign row_m1 = bnd_q.row - row_t'(1);
  assign col_m1 = bnd_q.col - col_t'(1);

  always_comb begin
    unique case (idx_q)
      SLOT_PREV_ROW: begin
        out_row_o = row_m1;
        out_col_o = col_m1;
      end
      SLOT_SECOND: begin
        out_row_o = bnd_q.flush_col ? row_m1 : bnd_q.row;
        out_col_o = bnd_q.flush_col ? bnd_q.col : col_m1;
      end
      SLOT_LAST_ROW: begin
        out_row_o = bnd_q.row;
        out_col_o = col_m1;
      end
      SLOT_CORNER: begin
        out_row_o = bnd_q.row;
        out_col_o = bnd_q.col;
      end
      default: begin
        out_row_o = bnd_q.row;
        out_col_o = bnd_q.col;
      end
    endcase
  end

  assign out_valid_o    = valid_q;
  assign magnitude_o    = bnd_q.mag[idx_q];
  assign last_of_run_o  = at_last;
  assign end_of_frame_o = (idx_q == SLOT_CORNER);

endmodule

`default_nettype wire

### hdl/sobhf_checker.sv
// ----------------------------------------------------------------------------
// sobhf_checker
// Port-level checks on the result channel of the Sobel edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sobhf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [9:0] out_row_o,
  input logic [9:0] out_col_o,
  input logic [7:0] magnitude_o,
  input logic       last_of_run_o,
  input logic       end_of_frame_o
);

  // a stalled result holds
  `SOBHF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_row_o) && $stable(out_col_o) && $stable(magnitude_o) && $stable(last_of_run_o) && $stable(end_of_frame_o), "stalled result changed")

  // frame end always closes the run of its pixel
  `SOBHF_ASSERT_NOW(a_eof_last, out_valid_o && end_of_frame_o, last_of_run_o, "frame end not last of run")

  // results of one pixel leave back to back
  `SOBHF_ASSERT_NEXT(a_run_cont, out_valid_o && out_ready_i && !last_of_run_o, out_valid_o, "gap inside a run")

endmodule

bind sobel_horizontal_edge_filter_top sobhf_checker u_sobhf_checker (.*);

`default_nettype wire

### tb/sobhf_tb_pkg.sv
// ----------------------------------------------------------------------------
// sobhf_tb_pkg
// Scoreboard for the horizontal Sobel edge filter testbench. It tracks the
// frame position, both line stores and the 3x3 window for every pixel request
// taken by the block. It queues the gradients that pixel must produce and
// compares each result request against the oldest queued gradient.
// ----------------------------------------------------------------------------
package sobhf_tb_pkg;

  import sobhf_pkg::*;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned LINE_LEN   = MAX_WIDTH_DEF;
  localparam int unsigned FRAME_ROWS = MAX_HEIGHT_DEF;

  // One expected or observed result request
  typedef struct packed {
    row_t row;
    col_t col;
    pix_t mag;
    logic last_of_run;
    logic end_of_frame;
  } grad_t;

  class sobel_grad_scoreboard;

    pix_t        older_line [LINE_LEN];
    pix_t        newer_line [LINE_LEN];
    pix_t        win [3][3];            // [tap][column], column 2 is newest
    int unsigned row_pos;
    int unsigned col_pos;
    cfg_t        width_reg;
    cfg_t        height_reg;
    grad_t       expected_grads[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < LINE_LEN; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = cfg_t'(CFG_RESET);
      height_reg = cfg_t'(CFG_RESET);
      mismatches = 0;
    endfunction

    // Size register as the block uses it: at least 2, at most the given maximum
    function int unsigned effective_dim(input cfg_t v, input int unsigned maxv);
      if (v < 2) begin
        return 2;
      end
      if (v > maxv) begin
        return maxv;
      end
      return v;
    endfunction

    function int unsigned frame_pixels();
      return effective_dim(width_reg, LINE_LEN) * effective_dim(height_reg, FRAME_ROWS);
    endfunction

    // Any size write restarts the frame; line stores keep their contents
    function void write_size(input logic [CFG_IDX_W-1:0] idx, input cfg_t val);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
      row_pos = 0;
      col_pos = 0;
    endfunction

    // Vertical 1,2,1 sum of a window column; on the bottom row the lower tap
    // repeats the center pixel
    function int unsigned tap_sum(input int j, input bit bottom);
      int unsigned t;
      int unsigned m;
      int unsigned b;
      t = win[0][j];
      m = win[1][j];
      b = win[2][j];
      if (bottom) begin
        return m + 3 * b;
      end
      return t + 2 * m + b;
    endfunction

    function grad_t make_grad(input int unsigned r, input int unsigned c, input int j_left,
                              input bit bottom, input int unsigned w, input int unsigned h);
      grad_t       g;
      int unsigned lv;
      int unsigned rv;
      int unsigned diff;
      lv   = tap_sum(j_left, bottom);
      rv   = tap_sum(2, bottom);
      diff = (rv >= lv) ? rv - lv : lv - rv;
      if (diff > 255) begin
        diff = 255;
      end
      g.row          = row_t'(r);
      g.col          = col_t'(c);
      g.mag          = pix_t'(diff);
      g.last_of_run  = 1'b0;
      g.end_of_frame = (r == h - 1 && c == w - 1);
      return g;
    endfunction

    // Advance the model by one accepted pixel and queue its gradients
    function void note_pixel(input pix_t p);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int          j_left;
      pix_t        top;
      pix_t        mid;
      pix_t        bot;
      grad_t       run[$];
      w = effective_dim(width_reg, LINE_LEN);
      h = effective_dim(height_reg, FRAME_ROWS);
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end

      // line stores: first row only fills, later rows shift down
      if (r == 0) begin
        newer_line[c] = p;
        top = p;
        mid = p;
        bot = p;
      end else begin
        mid = newer_line[c];
        top = (r >= 2) ? older_line[c] : mid;
        bot = p;
        older_line[c] = mid;
        newer_line[c] = p;
      end

      // window shift
      for (int j = 0; j < 3; j++) begin
        win[j][0] = win[j][1];
        win[j][1] = win[j][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;

      // results in raster order; row and column ends flush
      if (r >= 1 && c >= 1) begin
        j_left = (c == 1) ? 1 : 0;
        run.push_back(make_grad(r - 1, c - 1, j_left, 1'b0, w, h));
        if (c == w - 1) begin
          run.push_back(make_grad(r - 1, c, 1, 1'b0, w, h));
        end
        if (r == h - 1) begin
          run.push_back(make_grad(r, c - 1, j_left, 1'b1, w, h));
          if (c == w - 1) begin
            run.push_back(make_grad(r, c, 1, 1'b1, w, h));
          end
        end
      end
      if (run.size() > 0) begin
        run[run.size() - 1].last_of_run = 1'b1;
      end
      foreach (run[k]) begin
        expected_grads.push_back(run[k]);
      end

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
        end
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, input longint unsigned stamp);
      $display("%0d ns: %s mismatch, expected %0d, actual %0d", stamp, name, want, got);
      mismatches++;
    endfunction

    // Compare one result request with the oldest queued gradient
    function void check_result(input row_t row, input col_t col, input pix_t mag,
                               input logic last_of_run, input logic end_of_frame,
                               input longint unsigned stamp);
      grad_t want;
      if (expected_grads.size() == 0) begin
        $display("%0d ns: result with none expected, actual row %0d col %0d mag %0d",
                 stamp, row, col, mag);
        mismatches++;
        return;
      end
      want = expected_grads.pop_front();
      if (row !== want.row) begin
        report_field("out_row", want.row, row, stamp);
      end
      if (col !== want.col) begin
        report_field("out_col", want.col, col, stamp);
      end
      if (mag !== want.mag) begin
        report_field("magnitude", want.mag, mag, stamp);
      end
      if (last_of_run !== want.last_of_run) begin
        report_field("last_of_run", want.last_of_run, last_of_run, stamp);
      end
      if (end_of_frame !== want.end_of_frame) begin
        report_field("end_of_frame", want.end_of_frame, end_of_frame, stamp);
      end
    endfunction

  endclass

endpackage

### tb/tb_sobel_horizontal_edge_filter_top.sv
// ----------------------------------------------------------------------------
// tb_sobel_horizontal_edge_filter_top
// Self-checking bench for the streaming horizontal Sobel edge filter.
// ----------------------------------------------------------------------------
// Drives pixel requests in bursts with random gaps while the result side
// stalls on its own changing pattern. Every request taken is fed to the
// scoreboard, which predicts the gradients; every result request is checked
// field by field. Frame sizes sweep tiny, clamped and maximum settings, and
// partial frames are cut short by size writes.
// ----------------------------------------------------------------------------
module tb_sobel_horizontal_edge_filter_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sobhf_pkg::*;
  import sobhf_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS    = 408;
  localparam int unsigned LARGE_FRAME_CAP = 40;

  // Two 3x3 frames (rising, then falling ramps, both saturating) and a 2x2 one
  localparam pix_t DIRECTED_PIX [22] = '{
    8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255,
    8'd255, 8'd128, 8'd0,   8'd255, 8'd128, 8'd0,   8'd255, 8'd128, 8'd0,
    8'h55,  8'hAA,  8'hAA,  8'h55
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  cfg_t                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pix_t                 pixel_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  row_t                 out_row_o;
  col_t                 out_col_o;
  pix_t                 magnitude_o;
  logic                 last_of_run_o;
  logic                 end_of_frame_o;

  sobel_grad_scoreboard sb = new();
  int unsigned          burst_left = 0;
  int unsigned          cycle_count = 0;

  sobel_horizontal_edge_filter_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .magnitude_o    (magnitude_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Monitor: both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_pixel(pixel_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_row_o, out_col_o, magnitude_o, last_of_run_o,
                        end_of_frame_o, $time);
      end
    end
  end

  // Result side backpressure in randomly chosen modes
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 150);
      period = $urandom_range(2, 5);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ready_i <= (tick % period == 0);
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 2) == 0);
          end
        endcase
      end
    end
  end

  function automatic pix_t random_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Size value: mostly small, sometimes below two or at/above the maximum
  function automatic cfg_t pick_dim(input int unsigned top_small);
    case ($urandom_range(0, 9))
      0: return cfg_t'($urandom_range(0, 1));
      1: return cfg_t'($urandom_range(1024, 2047));
      default: return cfg_t'($urandom_range(2, top_small));
    endcase
  endfunction

  // Idle gap, then choose the next burst length
  task automatic idle_gap();
    int unsigned gap;
    gap = $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      pixel_i    <= pix_t'($urandom);
    end
    if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(40, 120);
    end else begin
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // One pixel request, held until taken
  task automatic send_pixel(input pix_t p);
    if (burst_left == 0) begin
      idle_gap();
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_i    <= p;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every queued result, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_grads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_t val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_size(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // New frame size; which selects the registers to write (bit 0 width)
  task automatic set_frame(input cfg_t w_val, input cfg_t h_val, input logic [1:0] which);
    wait_drained();
    if (which[0]) begin
      write_reg(REG_IMAGE_WIDTH, w_val);
    end
    if (which[1]) begin
      write_reg(REG_IMAGE_HEIGHT, h_val);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned random_sent;
    int unsigned npix;
    int unsigned frame;
    cfg_t        w_val;
    cfg_t        h_val;
    random_sent = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: saturating ramps over two back-to-back 3x3 frames
    set_frame(11'd3, 11'd3, 2'b11);
    for (int k = 0; k < 18; k++) begin
      send_pixel(DIRECTED_PIX[k]);
    end
    // Sizes below two act as two
    set_frame(11'd0, 11'd1, 2'b11);
    for (int k = 18; k < 22; k++) begin
      send_pixel(DIRECTED_PIX[k]);
    end

    // Random frames: mostly whole ones, some cut short by a size write
    while (random_sent < RANDOM_ITEMS) begin
      w_val = pick_dim(12);
      h_val = pick_dim(8);
      case ($urandom_range(0, 4))
        0: set_frame(w_val, h_val, 2'b01);
        1: set_frame(w_val, h_val, 2'b10);
        default: set_frame(w_val, h_val, 2'b11);
      endcase
      frame = sb.frame_pixels();
      if (frame > LARGE_FRAME_CAP) begin
        npix = $urandom_range(1, LARGE_FRAME_CAP);
      end else begin
        npix = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
          npix += $urandom_range(1, frame - 1);
        end
      end
      // keep the total pixel count on budget
      if (npix > RANDOM_ITEMS - random_sent) begin
        npix = RANDOM_ITEMS - random_sent;
      end
      random_sent += npix;
      repeat (npix) send_pixel(random_pixel());
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_grads.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
